>>> sv/cvsde_pkg.sv
package cvsde_pkg;

    localparam int SampleWidth = 16;
    localparam int RegWidth    = 15;
    localparam int ByteWidth   = 8;
    localparam int CountWidth  = 3;
    localparam int BitsWidth   = 4;
    localparam int IndexWidth  = 2;

    localparam logic [RegWidth-1:0] DecayReset = 15'd32704;
    localparam logic [RegWidth-1:0] LeakReset  = 15'd32640;
    localparam logic [RegWidth-1:0] MinReset   = 15'd10;
    localparam logic [RegWidth-1:0] MaxReset   = 15'd1280;

    localparam logic [IndexWidth-1:0] REG_SYLLABIC_DECAY  = 2'd0;
    localparam logic [IndexWidth-1:0] REG_INTEGRATOR_LEAK = 2'd1;
    localparam logic [IndexWidth-1:0] REG_STEP_MIN        = 2'd2;
    localparam logic [IndexWidth-1:0] REG_STEP_MAX        = 2'd3;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic [RegWidth-1:0] syllabic_decay;
        logic [RegWidth-1:0] integrator_leak;
        logic [RegWidth-1:0] step_min;
        logic [RegWidth-1:0] step_max;
    } cfg_t;

endpackage

>>> sv/cvsd_encoder_bit_packer.sv
// A result passes through the input register and then the result register before it is presented.
// Throughput: one item per cycle while the result register is free or being drained; the encoder
// state update is combinational through the two Q15 products and the saturating adds.
// Items that cause no result still pass through the input register; encode items also update state.
// Reset (rst_n low, asynchronous) clears the encoder and packer state, empties both
// registers and restores the default register values.
module cvsd_encoder_bit_packer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [cvsde_pkg::SampleWidth-1:0]    s_tdata,   // [15:0] pcm_sample
    input  logic                                 s_tuser,   // [0] cmd
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,   // [7:0] packed_byte,
                                                            // [11:8] valid_bits, [15:12] zero
    input  logic                                 cfg_we,
    input  logic [cvsde_pkg::IndexWidth-1:0]     cfg_index,
    input  logic [cvsde_pkg::RegWidth-1:0]       cfg_data
);

    cvsde_pkg::cfg_t cfg_reg;

    logic                                     in_valid_reg;
    logic                                     in_cmd_reg;
    logic signed [cvsde_pkg::SampleWidth-1:0] in_sample_reg;

    logic [cvsde_pkg::ByteWidth-1:0]  partial_reg, partial_next;
    logic [cvsde_pkg::CountWidth-1:0] count_reg, count_next;

    logic                             out_valid_reg;
    logic [cvsde_pkg::ByteWidth-1:0]  out_byte_reg;
    logic [cvsde_pkg::BitsWidth-1:0]  out_bits_reg;

    logic                             advance;
    logic                             encode;
    logic                             code_bit;
    logic                             emit;
    logic [cvsde_pkg::ByteWidth-1:0]  emit_byte;
    logic [cvsde_pkg::BitsWidth-1:0]  emit_bits;
    logic [cvsde_pkg::ByteWidth-1:0]  shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.syllabic_decay  <= cvsde_pkg::DecayReset;
            cfg_reg.integrator_leak <= cvsde_pkg::LeakReset;
            cfg_reg.step_min        <= cvsde_pkg::MinReset;
            cfg_reg.step_max        <= cvsde_pkg::MaxReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cvsde_pkg::REG_SYLLABIC_DECAY:  cfg_reg.syllabic_decay  <= cfg_data;
                cvsde_pkg::REG_INTEGRATOR_LEAK: cfg_reg.integrator_leak <= cfg_data;
                cvsde_pkg::REG_STEP_MIN:        cfg_reg.step_min        <= cfg_data;
                cvsde_pkg::REG_STEP_MAX:        cfg_reg.step_max        <= cfg_data;
                default: ;
            endcase
        end
    end

    // The held item moves on whenever the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign encode   = advance && (in_cmd_reg == cvsde_pkg::CMD_ENCODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg    <= s_tuser;
            in_sample_reg <= s_tdata;
        end
    end

    cvsde_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .encode   (encode),
        .sample   (in_sample_reg),
        .cfg      (cfg_reg),
        .code_bit (code_bit)
    );

    assign shifted = partial_reg << (4'd8 - {1'b0, count_reg});

    always_comb
    begin
        partial_next = partial_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        emit_byte    = shifted;
        emit_bits    = {1'b0, count_reg};
        if (in_cmd_reg == cvsde_pkg::CMD_FLUSH)
        begin
            // A flush with nothing pending leaves everything as it is.
            if (count_reg != '0)
            begin
                emit         = 1'b1;
                partial_next = '0;
                count_next   = '0;
            end
        end
        else
        begin
            partial_next = {partial_reg[cvsde_pkg::ByteWidth-2:0], code_bit};
            count_next   = count_reg + 3'd1;
            if (count_reg == 3'd7)
            begin
                emit      = 1'b1;
                emit_byte = partial_next;
                emit_bits = 4'd8;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            count_reg   <= '0;
        end
        else if (advance)
        begin
            partial_reg <= partial_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_byte_reg <= emit_byte;
            out_bits_reg <= emit_bits;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_bits_reg, out_byte_reg};

endmodule

>>> sv/cvsde_core.sv
module cvsde_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    encode,
    input  logic signed [cvsde_pkg::SampleWidth-1:0] sample,
    input  cvsde_pkg::cfg_t                         cfg,
    output logic                                    code_bit
);

    logic signed [cvsde_pkg::SampleWidth-1:0] estimate_reg, estimate_next;
    logic [cvsde_pkg::RegWidth-1:0]           step_reg, step_next;
    logic                                     last_bit_reg, second_bit_reg;

    logic                                     run;
    logic [2*cvsde_pkg::RegWidth-1:0]         step_prod;
    logic [cvsde_pkg::RegWidth:0]             step_sum;
    logic signed [2*cvsde_pkg::SampleWidth-1:0] est_prod;
    logic signed [cvsde_pkg::SampleWidth-1:0] leaked;
    logic signed [cvsde_pkg::SampleWidth+1:0] est_sum;

    assign code_bit = (sample > estimate_reg);
    assign run      = (code_bit == last_bit_reg) && (code_bit == second_bit_reg);

    // Both decays are floored Q15 products; taking the upper bits of the product gives the floor.
    assign step_prod = cfg.syllabic_decay * step_reg;
    assign step_sum  = {1'b0, step_prod[2*cvsde_pkg::RegWidth-1:cvsde_pkg::RegWidth]}
                     + {1'b0, (run ? cfg.step_max : cfg.step_min)};
    assign step_next = step_sum[cvsde_pkg::RegWidth] ? {cvsde_pkg::RegWidth{1'b1}}
                                                     : step_sum[cvsde_pkg::RegWidth-1:0];

    assign est_prod = estimate_reg * $signed({1'b0, cfg.integrator_leak});
    assign leaked   = est_prod[2*cvsde_pkg::SampleWidth-2:cvsde_pkg::RegWidth];

    always_comb
    begin
        if (code_bit)
            est_sum = {{2{leaked[cvsde_pkg::SampleWidth-1]}}, leaked}
                    + $signed({3'b000, step_next});
        else
            est_sum = {{2{leaked[cvsde_pkg::SampleWidth-1]}}, leaked}
                    - $signed({3'b000, step_next});

        if (est_sum > 18'sd32767)
            estimate_next = 16'sh7FFF;
        else if (est_sum < -18'sd32768)
            estimate_next = -16'sh8000;
        else
            estimate_next = est_sum[cvsde_pkg::SampleWidth-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estimate_reg   <= '0;
            step_reg       <= '0;
            last_bit_reg   <= 1'b0;
            second_bit_reg <= 1'b0;
        end
        else if (encode)
        begin
            estimate_reg   <= estimate_next;
            step_reg       <= step_next;
            last_bit_reg   <= code_bit;
            second_bit_reg <= last_bit_reg;
        end
    end

endmodule

>>> dv/tb_cvsd_encoder_bit_packer.sv
`timescale 1ns / 1ps

module tb_cvsd_encoder_bit_packer;

    localparam int CycleLimit = 200000;
    localparam int IdlePercent = 18;
    localparam int SettleCycles = 4;

    typedef struct {
        logic [cvsde_pkg::ByteWidth-1:0] code_byte;
        logic [cvsde_pkg::BitsWidth-1:0] valid_count;
    } byte_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [cvsde_pkg::SampleWidth-1:0] s_tdata = '0;
    logic                              s_tuser = cvsde_pkg::CMD_ENCODE;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [15:0]                       m_tdata;
    logic                              cfg_we = 1'b0;
    logic [cvsde_pkg::IndexWidth-1:0]  cfg_index = cvsde_pkg::REG_SYLLABIC_DECAY;
    logic [cvsde_pkg::RegWidth-1:0]    cfg_data = '0;

    // Predictor state, kept in step with every accepted transfer.
    cvsde_pkg::cfg_t                          cfg_model;
    logic signed [cvsde_pkg::SampleWidth-1:0] est_q;
    logic [cvsde_pkg::RegWidth-1:0]           step_q;
    logic                                     hist_last;
    logic                                     hist_prev;
    logic [cvsde_pkg::ByteWidth-1:0]          pack_byte;
    logic [cvsde_pkg::CountWidth-1:0]         pack_count;

    byte_result_t byte_queue[$];
    int           errors = 0;
    int           cycle_count = 0;
    bit           no_gaps = 1'b0;
    int           walk = 0;
    int           slope = 500;

    cvsd_encoder_bit_packer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= no_gaps || ($urandom_range(99) >= IdlePercent);
    end

    always @(posedge clk)
    begin : check_result
        byte_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (byte_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = byte_queue.pop_front();
                if (m_tdata[7:0] !== want.code_byte)
                begin
                    $display("%0t: packed_byte mismatch, expected %h, actual %h",
                             $time, want.code_byte, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[11:8] !== want.valid_count)
                begin
                    $display("%0t: valid_bits mismatch, expected %0d, actual %0d",
                             $time, want.valid_count, m_tdata[11:8]);
                    errors++;
                end
                if (m_tdata[15:12] !== 4'd0)
                begin
                    $display("%0t: padding mismatch, expected 0, actual %h",
                             $time, m_tdata[15:12]);
                    errors++;
                end
            end
        end
    end

    task automatic encode_and_pack(input logic cmd,
                                   input logic signed [cvsde_pkg::SampleWidth-1:0] sample);
        byte_result_t res;
        logic         code_bit;
        logic         run;
        longint       step_next;
        longint       est_next;
        if (cmd == cvsde_pkg::CMD_FLUSH)
        begin
            if (pack_count != 0)
            begin
                res.code_byte = pack_byte << (cvsde_pkg::ByteWidth - int'(pack_count));
                res.valid_count = {1'b0, pack_count};
                byte_queue = {byte_queue, res};
                pack_byte = '0;
                pack_count = '0;
            end
            return;
        end
        // A tie between sample and estimate counts as a negative bit.
        code_bit = (sample > est_q);
        run = (code_bit == hist_last) && (code_bit == hist_prev);
        step_next = ((longint'(cfg_model.syllabic_decay) * longint'(step_q)) >>> 15)
                    + longint'(run ? cfg_model.step_max : cfg_model.step_min);
        if (step_next > 32767)
            step_next = 32767;
        step_q = step_next[cvsde_pkg::RegWidth-1:0];
        // Arithmetic shift of the signed product floors toward minus infinity.
        est_next = (longint'(est_q) * longint'(cfg_model.integrator_leak)) >>> 15;
        est_next = code_bit ? est_next + longint'(step_q) : est_next - longint'(step_q);
        if (est_next > 32767)
            est_next = 32767;
        if (est_next < -32768)
            est_next = -32768;
        est_q = est_next[cvsde_pkg::SampleWidth-1:0];
        hist_prev = hist_last;
        hist_last = code_bit;
        if (pack_count == 3'd7)
        begin
            res.code_byte = {pack_byte[6:0], code_bit};
            res.valid_count = 4'd8;
            byte_queue = {byte_queue, res};
            pack_byte = '0;
            pack_count = '0;
        end
        else
        begin
            pack_byte = {pack_byte[6:0], code_bit};
            pack_count = pack_count + 1'b1;
        end
    endtask

    task automatic send_item(input logic cmd, input logic [cvsde_pkg::SampleWidth-1:0] sample);
        while (!no_gaps && $urandom_range(99) < IdlePercent)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= sample;
        do
            @(posedge clk);
        while (!s_tready);
        encode_and_pack(cmd, sample);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (byte_queue.size() != 0)
            @(posedge clk);
        // Flushes with nothing pending and partial bytes leave no result to wait on.
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic set_config(input logic [cvsde_pkg::RegWidth-1:0] decay,
                              input logic [cvsde_pkg::RegWidth-1:0] leak,
                              input logic [cvsde_pkg::RegWidth-1:0] inc_min,
                              input logic [cvsde_pkg::RegWidth-1:0] inc_max);
        logic [cvsde_pkg::RegWidth-1:0] values[4];
        logic [cvsde_pkg::IndexWidth-1:0] index_list[4];
        values = '{decay, leak, inc_min, inc_max};
        index_list = '{cvsde_pkg::REG_SYLLABIC_DECAY, cvsde_pkg::REG_INTEGRATOR_LEAK,
                       cvsde_pkg::REG_STEP_MIN, cvsde_pkg::REG_STEP_MAX};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= index_list[i];
            cfg_data <= values[i];
            @(posedge clk);
            case (index_list[i])
                cvsde_pkg::REG_SYLLABIC_DECAY:  cfg_model.syllabic_decay = values[i];
                cvsde_pkg::REG_INTEGRATOR_LEAK: cfg_model.integrator_leak = values[i];
                cvsde_pkg::REG_STEP_MIN:        cfg_model.step_min = values[i];
                cvsde_pkg::REG_STEP_MAX:        cfg_model.step_max = values[i];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [cvsde_pkg::RegWidth-1:0] pick_register_value();
        case ($urandom_range(3))
            0: return '0;
            1: return 15'h7FFF;
            default: return cvsde_pkg::RegWidth'($urandom);
        endcase
    endfunction

    function automatic int clamp_sample(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Slowly drifting input for the largest share, so that runs of equal bits build up the step,
    // with full-range noise, extremes and exact ties mixed in.
    function automatic logic [cvsde_pkg::SampleWidth-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
        begin
            if ($urandom_range(15) == 0)
                slope = int'($urandom_range(6000)) - 3000;
            walk = clamp_sample(walk + slope);
            if (walk == 32767 || walk == -32768)
                slope = -slope;
            return cvsde_pkg::SampleWidth'(walk);
        end
        else if (sel < 75)
            return cvsde_pkg::SampleWidth'($urandom);
        else if (sel < 88)
        begin
            case ($urandom_range(3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return cvsde_pkg::SampleWidth'(clamp_sample(int'(est_q) + int'($urandom_range(2)) - 1));
    endfunction

    task automatic test_packer_edges;
        send_item(cvsde_pkg::CMD_FLUSH, 16'h1234);
        send_item(cvsde_pkg::CMD_ENCODE, 16'h0000);
        repeat (3) send_item(cvsde_pkg::CMD_ENCODE, 16'h7FFF);
        repeat (3) send_item(cvsde_pkg::CMD_ENCODE, 16'h8000);
        // Seven bits are pending here, so the flush emits a left-aligned byte.
        send_item(cvsde_pkg::CMD_FLUSH, 16'hFFFF);
        repeat (8) send_item(cvsde_pkg::CMD_ENCODE, cvsde_pkg::SampleWidth'($urandom));
        send_item(cvsde_pkg::CMD_FLUSH, 16'h0000);
    endtask

    task automatic test_saturation;
        set_config(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        repeat (3) send_item(cvsde_pkg::CMD_ENCODE, 16'h7FFF);
        repeat (3) send_item(cvsde_pkg::CMD_ENCODE, 16'h8000);
        set_config('0, '0, '0, '0);
        send_item(cvsde_pkg::CMD_ENCODE, 16'h0000);
        send_item(cvsde_pkg::CMD_ENCODE, 16'hFFFF);
        send_item(cvsde_pkg::CMD_FLUSH, 16'h0000);
    endtask

    task automatic run_random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 6)
                send_item(cvsde_pkg::CMD_FLUSH, cvsde_pkg::SampleWidth'($urandom));
            else
                send_item(cvsde_pkg::CMD_ENCODE, pick_sample());
        end
    endtask

    task automatic test_random_streams;
        set_config(cvsde_pkg::DecayReset, cvsde_pkg::LeakReset,
                   cvsde_pkg::MinReset, cvsde_pkg::MaxReset);
        run_random_phase(280);
        no_gaps = 1'b1;
        set_config(pick_register_value(), pick_register_value(),
                   cvsde_pkg::RegWidth'($urandom_range(400)),
                   cvsde_pkg::RegWidth'($urandom_range(4000)));
        run_random_phase(280);
        no_gaps = 1'b0;
        set_config(15'h7FFF, 15'h7FFF, '0, 15'h7FFF);
        run_random_phase(280);
        set_config('0, '0, cvsde_pkg::RegWidth'($urandom_range(200)),
                   cvsde_pkg::RegWidth'($urandom));
        run_random_phase(280);
        set_config(pick_register_value(), pick_register_value(),
                   pick_register_value(), pick_register_value());
        run_random_phase(280);
    endtask

    initial
    begin
        cfg_model.syllabic_decay = cvsde_pkg::DecayReset;
        cfg_model.integrator_leak = cvsde_pkg::LeakReset;
        cfg_model.step_min = cvsde_pkg::MinReset;
        cfg_model.step_max = cvsde_pkg::MaxReset;
        est_q = '0;
        step_q = '0;
        hist_last = 1'b0;
        hist_prev = 1'b0;
        pack_byte = '0;
        pack_count = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_packer_edges();
        test_saturation();
        test_random_streams();

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/cvsde_pkg.sv
sv/cvsde_core.sv
sv/cvsd_encoder_bit_packer.sv
dv/tb_cvsd_encoder_bit_packer.sv
